[rtl/mtce_pkg.sv]
// shared types, constants and tag helper functions of the markup tag content extractor
package mtce_pkg;

    // tag and result sizing
    localparam int MAX_TAG_CHARS = 8;
    localparam int TAG_BITS      = 8 * MAX_TAG_CHARS;
    localparam int TAG_SEL_W     = $clog2(MAX_TAG_CHARS);
    localparam int TAG_LEN_W     = 4;
    localparam int RUN_DEPTH     = MAX_TAG_CHARS + 2;
    localparam int CNT_W         = $clog2(RUN_DEPTH + 1);
    localparam int IDX_W         = $clog2(RUN_DEPTH);

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = TAG_BITS;

    localparam logic [CFG_INDEX_W-1:0] REG_TAG_CHARS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIP_INNER = 2'd2;

    // register reset values
    localparam logic [TAG_BITS-1:0]  RST_TAG_CHARS   = '0;
    localparam logic [TAG_LEN_W-1:0] RST_TAG_LENGTH  = 4'd1;
    localparam logic                 RST_STRIP_INNER = 1'b1;

    // markup characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_DISCARD = 2'd2
    } t_kind;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_slot;

    // all results caused by one input byte, packed from slot 0
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        t_slot [RUN_DEPTH-1:0]       slot;
    } t_run;

    // chain control shared by every cell
    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

    // character of the tag name at a position
    function automatic logic [7:0] tag_byte(input logic [TAG_BITS-1:0] tag,
                                            input logic [TAG_SEL_W-1:0] sel);
        return tag[{sel, 3'b000} +: 8];
    endfunction

    // character of the opening sequence "<" + tag
    function automatic logic [7:0] open_char(input logic [TAG_BITS-1:0] tag,
                                             input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] off;
        off = pos - CNT_W'(1);
        if (pos == '0) begin
            return CH_LT;
        end
        return tag_byte(tag, off[TAG_SEL_W-1:0]);
    endfunction

    // character of the closing sequence "</" + tag
    function automatic logic [7:0] close_char(input logic [TAG_BITS-1:0] tag,
                                              input logic [CNT_W-1:0] pos);
        logic [CNT_W-1:0] off;
        off = pos - CNT_W'(2);
        if (pos == '0) begin
            return CH_LT;
        end
        if (pos == CNT_W'(1)) begin
            return CH_SLASH;
        end
        return tag_byte(tag, off[TAG_SEL_W-1:0]);
    endfunction

endpackage

[rtl/mtce_in_if.sv]
// input channel: one text byte per transfer
interface mtce_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[rtl/mtce_out_if.sv]
// output channel: one result item per transfer
interface mtce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input last_of_run,
                    output ready);
endinterface

[rtl/mtce_parser.sv]
// tag matcher, inner tag filter and result run builder with configuration registers
module mtce_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_byte,
    input  logic                                i_end,
    input  logic                                i_cfg_we,
    input  logic [mtce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mtce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output mtce_pkg::t_run                      o_run
);

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_SKIP    = 2'd1,
        PH_CONTENT = 2'd2
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [mtce_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic                                r_inside, n_inside;
    logic [mtce_pkg::TAG_BITS-1:0]       r_tag_chars;
    logic [mtce_pkg::TAG_LEN_W-1:0]      r_tag_length;
    logic                                r_strip_inner;

    logic [mtce_pkg::CNT_W-1:0]          w_len;
    logic [mtce_pkg::CNT_W-1:0]          w_close_full;
    logic [mtce_pkg::CNT_W-1:0]          w_open_full;
    logic [mtce_pkg::CNT_W-1:0]          w_close_pos;
    logic [mtce_pkg::CNT_W-1:0]          w_open_pos;
    mtce_pkg::t_run                      w_rel;
    logic                                w_rel_inside;
    mtce_pkg::t_run                      w_run;

    // effective tag length, clamped to the supported maximum
    always_comb begin
        if (r_tag_length > mtce_pkg::TAG_LEN_W'(mtce_pkg::MAX_TAG_CHARS)) begin
            w_len = mtce_pkg::CNT_W'(mtce_pkg::MAX_TAG_CHARS);
        end else begin
            w_len = mtce_pkg::CNT_W'(r_tag_length);
        end
    end

    // sequence lengths and match positions, a stale count restarts at zero
    assign w_close_full = w_len + mtce_pkg::CNT_W'(2);
    assign w_open_full  = w_len + mtce_pkg::CNT_W'(1);
    assign w_close_pos  = (r_cnt >= w_close_full) ? '0 : r_cnt;
    assign w_open_pos   = (r_cnt >= w_open_full) ? '0 : r_cnt;

    // release of held closing bytes plus the current byte through the inner tag filter
    always_comb begin
        logic                           ins;
        logic [mtce_pkg::CNT_W-1:0]     idx;
        logic [7:0]                     cand;
        logic                           used;
        logic                           emit;
        ins   = r_inside;
        idx   = '0;
        w_rel = '0;
        for (int p = 0; p < mtce_pkg::RUN_DEPTH; p++) begin
            if (mtce_pkg::CNT_W'(p) < w_close_pos) begin
                cand = mtce_pkg::close_char(r_tag_chars, mtce_pkg::CNT_W'(p));
                used = 1'b1;
            end else begin
                cand = i_byte;
                used = (mtce_pkg::CNT_W'(p) == w_close_pos) && (i_byte != mtce_pkg::CH_LT);
            end
            emit = used && (!r_strip_inner || (!ins && cand != mtce_pkg::CH_LT));
            if (used && r_strip_inner) begin
                if (ins) begin
                    if (cand == mtce_pkg::CH_GT) begin
                        ins = 1'b0;
                    end
                end else if (cand == mtce_pkg::CH_LT) begin
                    ins = 1'b1;
                end
            end
            if (emit) begin
                w_rel.slot[idx[mtce_pkg::IDX_W-1:0]].data = cand;
                w_rel.slot[idx[mtce_pkg::IDX_W-1:0]].kind = mtce_pkg::KIND_CONTENT;
                idx = idx + mtce_pkg::CNT_W'(1);
            end
        end
        w_rel.count  = idx;
        w_rel_inside = ins;
    end

    // next state and result run for the byte on the input
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_inside = r_inside;
        w_run    = '0;
        unique case (r_phase)
            PH_SKIP: begin
                if (i_byte == mtce_pkg::CH_GT) begin
                    n_phase  = PH_CONTENT;
                    n_cnt    = '0;
                    n_inside = 1'b0;
                end
            end
            PH_CONTENT: begin
                if (i_byte == mtce_pkg::close_char(r_tag_chars, w_close_pos)) begin
                    if (w_close_pos + mtce_pkg::CNT_W'(1) == w_close_full) begin
                        w_run.count        = mtce_pkg::CNT_W'(1);
                        w_run.slot[0].kind = mtce_pkg::KIND_DONE;
                        n_phase            = PH_SEARCH;
                        n_cnt              = '0;
                        n_inside           = 1'b0;
                    end else begin
                        n_cnt = w_close_pos + mtce_pkg::CNT_W'(1);
                    end
                end else begin
                    w_run    = w_rel;
                    n_inside = w_rel_inside;
                    n_cnt    = (i_byte == mtce_pkg::CH_LT) ? mtce_pkg::CNT_W'(1) : '0;
                end
            end
            default: begin
                // searching, also for the unused phase code
                n_phase = PH_SEARCH;
                if (i_byte == mtce_pkg::open_char(r_tag_chars, w_open_pos)) begin
                    n_cnt = w_open_pos + mtce_pkg::CNT_W'(1);
                end else begin
                    n_cnt = (i_byte == mtce_pkg::CH_LT) ? mtce_pkg::CNT_W'(1) : '0;
                end
                if (n_cnt >= w_open_full) begin
                    n_phase = PH_SKIP;
                    n_cnt   = '0;
                end
            end
        endcase
        // end of text: an open item is reported discarded, state returns to reset
        if (i_end) begin
            if (n_phase == PH_SKIP || n_phase == PH_CONTENT) begin
                w_run              = '0;
                w_run.count        = mtce_pkg::CNT_W'(1);
                w_run.slot[0].kind = mtce_pkg::KIND_DISCARD;
            end
            n_phase  = PH_SEARCH;
            n_cnt    = '0;
            n_inside = 1'b0;
        end
    end

    // mark the last result of the run
    always_comb begin
        o_run = w_run;
        for (int j = 0; j < mtce_pkg::RUN_DEPTH; j++) begin
            o_run.slot[j].last = (mtce_pkg::CNT_W'(j + 1) == w_run.count);
        end
    end

    // parser state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SEARCH;
            r_cnt         <= '0;
            r_inside      <= 1'b0;
            r_tag_chars   <= mtce_pkg::RST_TAG_CHARS;
            r_tag_length  <= mtce_pkg::RST_TAG_LENGTH;
            r_strip_inner <= mtce_pkg::RST_STRIP_INNER;
        end else begin
            if (i_accept) begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_inside <= n_inside;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mtce_pkg::REG_TAG_CHARS:   r_tag_chars   <= i_cfg_data;
                    mtce_pkg::REG_TAG_LENGTH:  r_tag_length  <= i_cfg_data[mtce_pkg::TAG_LEN_W-1:0];
                    mtce_pkg::REG_STRIP_INNER: r_strip_inner <= i_cfg_data[0];
                    default: begin
                        // index beyond the register list
                    end
                endcase
            end
        end
    end

endmodule

[rtl/mtce_slot.sv]
// one cell of the output chain: holds a result and hands it toward the output
module mtce_slot (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mtce_pkg::t_chain_ctl    i_ctl,
    input  logic                    i_load_valid,
    input  mtce_pkg::t_slot         i_load_data,
    input  logic                    i_next_valid,
    input  mtce_pkg::t_slot         i_next_data,
    output logic                    o_valid,
    output mtce_pkg::t_slot         o_data
);

    logic               r_valid;
    mtce_pkg::t_slot    r_data;

    // occupancy: load a fresh run or take the neighbor's entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= i_load_valid;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end
    end

    // payload follows the same selection
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_load_data;
        end else if (i_ctl.shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/markup_tag_content_extractor.sv]
// top level of the markup tag content extractor
// Takes one text byte per transfer and streams out the content of every element whose
// opening tag starts with the configured name, then a completion marker per element, or a
// discard marker if the text ends inside an element. A byte is taken every cycle while the
// results of the previous byte fit and the output is ready: most bytes cause zero or one
// result and run at one byte per cycle. A byte breaking a partial closing match releases the
// held bytes, up to ten results, which leave one per cycle while the output is ready from a
// ten-cell output chain; the input waits until that chain is down to its final entry.
// Configuration must be written through the plain write port while idle (not enforced).
module markup_tag_content_extractor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mtce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mtce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mtce_in_if.sink                             i_in,
    mtce_out_if.source                          o_out
);

    mtce_pkg::t_run                         w_run;
    mtce_pkg::t_chain_ctl                   w_ctl;
    logic                                   w_accept;
    logic                                   w_take;
    logic [mtce_pkg::RUN_DEPTH-1:0]         w_valid;
    mtce_pkg::t_slot [mtce_pkg::RUN_DEPTH-1:0] w_data;
    logic [mtce_pkg::RUN_DEPTH-1:0]         w_next_valid;
    mtce_pkg::t_slot [mtce_pkg::RUN_DEPTH-1:0] w_next_data;

    // handshakes: accept when the chain is empty or its final entry leaves now
    assign w_take      = w_valid[0] && o_out.ready;
    assign i_in.ready  = !w_valid[0] || (o_out.ready && !w_valid[1]);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_ctl.load  = w_accept && (w_run.count != '0);
    assign w_ctl.shift = w_take;

    // matcher and run builder
    mtce_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_in.in_byte),
        .i_end       (i_in.end_of_text),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_run       (w_run)
    );

    // output chain, cell 0 drives the output channel
    for (genvar j = 0; j < mtce_pkg::RUN_DEPTH; j++) begin : g_chain
        if (j == mtce_pkg::RUN_DEPTH - 1) begin : g_tail
            assign w_next_valid[j] = 1'b0;
            assign w_next_data[j]  = '0;
        end else begin : g_link
            assign w_next_valid[j] = w_valid[j+1];
            assign w_next_data[j]  = w_data[j+1];
        end
        mtce_slot u_slot (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_load_valid (mtce_pkg::CNT_W'(j) < w_run.count),
            .i_load_data  (w_run.slot[j]),
            .i_next_valid (w_next_valid[j]),
            .i_next_data  (w_next_data[j]),
            .o_valid      (w_valid[j]),
            .o_data       (w_data[j])
        );
    end

    // output channel
    assign o_out.valid       = w_valid[0];
    assign o_out.out_byte    = w_data[0].data;
    assign o_out.kind        = w_data[0].kind;
    assign o_out.last_of_run = w_data[0].last;

`ifndef SYNTHESIS
    // an empty cell 0 means the whole chain is empty
    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[0] |-> (w_valid == '0))
        else $error("output chain has a gap");

    // a byte with results shows a result in the next cycle
    a_run_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_run.count != '0) |=> o_out.valid)
        else $error("accepted results not presented");

    // a result that is not last of its run has a successor queued
    a_run_intact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_of_run) |-> w_valid[1])
        else $error("run lost its tail");

    // a discard marker stands alone
    a_discard_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == mtce_pkg::KIND_DISCARD) |->
        (o_out.last_of_run && o_out.out_byte == 8'd0))
        else $error("discard marker not alone");
`endif

endmodule
